// ===== sv/ktl_pkg.sv =====
package ktl_pkg;

    localparam int KEYS_DEF  = 64;

    localparam int SLOT_W    = 6;
    localparam int TIME_W    = 32;
    localparam int VEC_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int CNT_W     = 7;
    localparam int STAT_W    = 2;
    localparam int WORD_W    = TIME_W + 3 * VEC_W;
    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 96;
    localparam int DIV_CNT_W = $clog2(FRAC_W + 1);

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] LS_INTERP = 2'd0;
    localparam logic [STAT_W-1:0] LS_BEFORE = 2'd1;
    localparam logic [STAT_W-1:0] LS_AFTER  = 2'd2;
    localparam logic [STAT_W-1:0] LS_EMPTY  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIV,
        ST_DIVW,
        ST_SUB,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic ld_d;
        logic ld_p;
    } t_blend_ctl;

endpackage

// ===== sv/ktl_ram.sv =====
module ktl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

// ===== sv/ktl_div.sv =====
module ktl_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ktl_pkg::TIME_W-1:0] i_num,
    input  logic [ktl_pkg::TIME_W-1:0] i_den,
    output logic                       o_done,
    output logic [ktl_pkg::FRAC_W-1:0] o_quo
);

    import ktl_pkg::*;

    logic [TIME_W-1:0]    r_rem, n_rem;
    logic [TIME_W-1:0]    r_den;
    logic [FRAC_W-1:0]    r_quo, n_quo;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [TIME_W:0]      sh;
    logic [TIME_W:0]      diff;
    logic                 take;

    // one quotient bit per cycle, numerator below denominator
    assign sh   = {r_rem, 1'b0};
    assign diff = sh - {1'b0, r_den};
    assign take = (sh >= {1'b0, r_den});

    always_comb begin
        n_rem = take ? diff[TIME_W-1:0] : sh[TIME_W-1:0];
        n_quo = {r_quo[FRAC_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== sv/ktl_blend.sv =====
module ktl_blend (
    input  logic                       i_clk,
    input  ktl_pkg::t_blend_ctl        i_ctl,
    input  logic [ktl_pkg::VEC_W-1:0]  i_a,
    input  logic [ktl_pkg::VEC_W-1:0]  i_b,
    input  logic [ktl_pkg::FRAC_W-1:0] i_frac,
    output logic [ktl_pkg::VEC_W-1:0]  o_res
);

    import ktl_pkg::*;

    localparam int D_W = VEC_W + 1;
    localparam int P_W = D_W + FRAC_W + 1;

    logic signed [D_W-1:0]    r_d;
    logic signed [P_W-1:0]    r_p;
    logic signed [FRAC_W:0]   frac_s;

    assign frac_s = signed'({1'b0, i_frac});

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_d) begin
            r_d <= signed'({i_b[VEC_W-1], i_b}) - signed'({i_a[VEC_W-1], i_a});
        end
        if (i_ctl.ld_p) begin
            r_p <= r_d * frac_s;
        end
    end

    // floor shift of the product, low word only
    assign o_res = i_a + r_p[FRAC_W+VEC_W-1:FRAC_W];

endmodule

// ===== sv/keyframe_track_lerp_core.sv =====
// channel   dir  signals                       contents
// s         in   i_s_tvalid/o_s_tready         tuser: func; tdata: key fields, query_time
// m         out  o_m_tvalid/i_m_tready         tuser: lookup_status; tdata: out_x/y/z
// cfg       in   i_cfg_wr_en/i_cfg_wr_data     key_count
//
// a load is written to the key memory as it is accepted; a query's time depends on the
// number n of valid keys, through the one-entry-per-cycle scan of the key memory, the 16-step
// serial divider and the single multiplier shared by the three components
// reset is synchronous, active low, and clears key_count and the sequencer
// one finished result waits in the output register while the next request runs

module keyframe_track_lerp_core #(
    parameter int KEYS = ktl_pkg::KEYS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [ktl_pkg::CNT_W-1:0]     i_cfg_wr_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // slot[5:0], key_time[37:6], key_x[69:38], key_y[101:70], key_z[133:102],
    // query_time[165:134], zero[167:166]
    input  logic [ktl_pkg::S_TDATA_W-1:0] i_s_tdata,
    // func[0]
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [ktl_pkg::M_TDATA_W-1:0] o_m_tdata,
    // lookup_status[1:0]
    output logic [ktl_pkg::STAT_W-1:0]    o_m_tuser
);

    import ktl_pkg::*;

    localparam int AW = $clog2(KEYS);
    localparam int NW = $clog2(KEYS + 1);

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_key_count;
    logic [NW-1:0]       r_n, n_n;
    logic [NW-1:0]       r_idx, n_idx;
    logic [NW-1:0]       r_cidx, n_cidx;
    logic                r_dv, n_dv;
    logic [TIME_W-1:0]   r_q, n_q;
    logic [WORD_W-1:0]   r_prv, n_prv;
    logic [WORD_W-1:0]   r_nxt, n_nxt;
    logic [FRAC_W-1:0]   r_frac, n_frac;
    logic [1:0]          r_comp, n_comp;
    logic [VEC_W-1:0]    r_res_x, n_res_x;
    logic [VEC_W-1:0]    r_res_y, n_res_y;
    logic [VEC_W-1:0]    r_res_z, n_res_z;
    logic [STAT_W-1:0]   r_stat, n_stat;
    logic                r_ovalid, n_ovalid;
    logic [M_TDATA_W-1:0] r_odata, n_odata;
    logic [STAT_W-1:0]   r_ostat, n_ostat;

    logic                s_acc;
    logic                func;
    logic [SLOT_W-1:0]   slot;
    logic                slot_ok;
    logic [WORD_W-1:0]   wr_word;
    logic                wr_en;
    logic                rd_en;
    logic [WORD_W-1:0]   rd_data;
    logic [NW-1:0]       n_clamp;
    logic [TIME_W-1:0]   el, dt;
    logic                div_start;
    logic                div_done;
    logic [FRAC_W-1:0]   div_quo;
    t_blend_ctl          bctl;
    logic [VEC_W-1:0]    bl_a, bl_b, bl_res;

    assign s_acc   = i_s_tvalid && o_s_tready;
    assign func    = i_s_tuser;
    assign slot    = i_s_tdata[SLOT_W-1:0];
    assign slot_ok = ({26'b0, slot} < 32'(KEYS));
    assign wr_word = i_s_tdata[SLOT_W+WORD_W-1:SLOT_W];
    assign wr_en   = s_acc && (func == FUNC_LOAD) && slot_ok;
    assign n_clamp = ({25'b0, r_key_count} > 32'(KEYS)) ? NW'(KEYS) : NW'(r_key_count);
    assign rd_en   = (r_state == ST_SCAN) && (r_idx < r_n);

    assign el = r_q - r_prv[TIME_W-1:0];
    assign dt = r_nxt[TIME_W-1:0] - r_prv[TIME_W-1:0];

    ktl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (KEYS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(slot)),
        .i_wr_data (wr_word),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    ktl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (el),
        .i_den   (dt),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        case (r_comp)
            2'd0: begin
                bl_a = r_prv[TIME_W+VEC_W-1:TIME_W];
                bl_b = r_nxt[TIME_W+VEC_W-1:TIME_W];
            end
            2'd1: begin
                bl_a = r_prv[TIME_W+2*VEC_W-1:TIME_W+VEC_W];
                bl_b = r_nxt[TIME_W+2*VEC_W-1:TIME_W+VEC_W];
            end
            default: begin
                bl_a = r_prv[WORD_W-1:TIME_W+2*VEC_W];
                bl_b = r_nxt[WORD_W-1:TIME_W+2*VEC_W];
            end
        endcase
    end

    ktl_blend u_blend (
        .i_clk  (i_clk),
        .i_ctl  (bctl),
        .i_a    (bl_a),
        .i_b    (bl_b),
        .i_frac (r_frac),
        .o_res  (bl_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_key_count <= '0;
            r_ovalid    <= 1'b0;
            r_dv        <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_dv     <= n_dv;
            if (i_cfg_wr_en) begin
                r_key_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_idx   <= n_idx;
        r_cidx  <= n_cidx;
        r_q     <= n_q;
        r_prv   <= n_prv;
        r_nxt   <= n_nxt;
        r_frac  <= n_frac;
        r_comp  <= n_comp;
        r_res_x <= n_res_x;
        r_res_y <= n_res_y;
        r_res_z <= n_res_z;
        r_stat  <= n_stat;
        r_odata <= n_odata;
        r_ostat <= n_ostat;
    end

    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_idx     = r_idx;
        n_cidx    = r_cidx;
        n_dv      = 1'b0;
        n_q       = r_q;
        n_prv     = r_prv;
        n_nxt     = r_nxt;
        n_frac    = r_frac;
        n_comp    = r_comp;
        n_res_x   = r_res_x;
        n_res_y   = r_res_y;
        n_res_z   = r_res_z;
        n_stat    = r_stat;
        n_odata   = r_odata;
        n_ostat   = r_ostat;
        n_ovalid  = r_ovalid && !i_m_tready;
        div_start = 1'b0;
        bctl      = '0;

        case (r_state)
            ST_IDLE: begin
                if (s_acc && (func == FUNC_QUERY)) begin
                    n_q   = i_s_tdata[SLOT_W+WORD_W+TIME_W-1:SLOT_W+WORD_W];
                    n_n   = n_clamp;
                    n_idx = '0;
                    if (n_clamp == '0) begin
                        n_res_x = '0;
                        n_res_y = '0;
                        n_res_z = '0;
                        n_stat  = LS_EMPTY;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_en) begin
                    n_idx  = r_idx + 1'b1;
                    n_cidx = r_idx;
                    n_dv   = 1'b1;
                end
                if (r_dv) begin
                    if (rd_data[TIME_W-1:0] > r_q) begin
                        n_dv = 1'b0;
                        if (r_cidx == '0) begin
                            n_res_x = rd_data[TIME_W+VEC_W-1:TIME_W];
                            n_res_y = rd_data[TIME_W+2*VEC_W-1:TIME_W+VEC_W];
                            n_res_z = rd_data[WORD_W-1:TIME_W+2*VEC_W];
                            n_stat  = LS_BEFORE;
                            n_state = ST_DONE;
                        end else begin
                            n_nxt   = rd_data;
                            n_state = ST_DIV;
                        end
                    end else begin
                        n_prv = rd_data;
                        if (r_cidx == r_n - 1'b1) begin
                            n_dv    = 1'b0;
                            n_res_x = rd_data[TIME_W+VEC_W-1:TIME_W];
                            n_res_y = rd_data[TIME_W+2*VEC_W-1:TIME_W+VEC_W];
                            n_res_z = rd_data[WORD_W-1:TIME_W+2*VEC_W];
                            n_stat  = LS_AFTER;
                            n_state = ST_DONE;
                        end
                    end
                end
            end
            ST_DIV: begin
                n_comp = '0;
                if (el >= dt) begin
                    n_frac  = '0;
                    n_state = ST_SUB;
                end else begin
                    div_start = 1'b1;
                    n_state   = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (div_done) begin
                    n_frac  = div_quo;
                    n_state = ST_SUB;
                end
            end
            ST_SUB: begin
                bctl.ld_d = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                bctl.ld_p = 1'b1;
                n_state   = ST_ADD;
            end
            ST_ADD: begin
                case (r_comp)
                    2'd0:    n_res_x = bl_res;
                    2'd1:    n_res_y = bl_res;
                    default: n_res_z = bl_res;
                endcase
                if (r_comp == 2'd2) begin
                    n_stat  = LS_INTERP;
                    n_state = ST_DONE;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = ST_SUB;
                end
            end
            ST_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = {r_res_z, r_res_y, r_res_x};
                    n_ostat  = r_stat;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostat;

endmodule
